// ===== rtl/deq_pkg.sv =====
// deq_pkg: shared constants, request and status codes, and pointer helpers
// for the double-ended queue. Depends on nothing; imported by double_ended_queue.
`timescale 1ns / 1ps

package deq_pkg;

  localparam int DEPTH     = 1024;
  localparam int PTR_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int MODE_W    = 3;
  localparam int VALUE_W   = 32;
  localparam int STATUS_W  = 2;
  localparam int DATA_W    = 32;

  localparam int IN_BITS     = MODE_W + VALUE_W;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS    = STATUS_W + DATA_W + CNT_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [PTR_W:0]   DEPTH_WIDE = (PTR_W + 1)'(DEPTH);
  localparam logic [PTR_W-1:0] LAST_SLOT  = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_PEEK_FRONT = 3'd4,
    MODE_PEEK_BACK  = 3'd5,
    MODE_SIZE       = 3'd6,
    MODE_CLEAR      = 3'd7
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // request in flight while the store read completes
  typedef struct packed {
    status_t            status;
    logic               rd;
    logic [CNT_W-1:0]   count;
  } stage_t;

  // circular add of two slot offsets, both below DEPTH
  function automatic logic [PTR_W-1:0] slot_add(input logic [PTR_W-1:0] base,
                                                input logic [PTR_W-1:0] off);
    logic [PTR_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= DEPTH_WIDE) begin
      sum = sum - DEPTH_WIDE;
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

// ===== rtl/deq_ram.sv =====
// deq_ram: generic single-write, single-read RAM with registered read data.
// Depends on nothing; instanced by the double-ended queue for its word store.
`timescale 1ns / 1ps

module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/double_ended_queue.sv =====
// double_ended_queue: fixed-capacity deque of 32-bit words on a circular store.
// Depends on deq_pkg and deq_ram.
//
// Usage: each request word on the in_ channel carries a mode and a value
// (push front/back, pop front/back, peek front/back, size, clear). Each request
// gives exactly one result word on the out_ channel: status, data and the
// count after the request. Pops and peeks on an empty deque report empty with
// zero data; a push on a full deque is dropped and reports full.
// Pipeline: the store read is registered at the edge that accepts a request;
// the read stage then loads the output register once out_ is free, and the
// result stays on out_ until it is taken.
// Throughput: one request per cycle when not stalled, set by the single
// write and single read port of the store; head and count update on accept.
// Stall: while a result waits with out_tready low, the output register and the
// read stage hold; in_tready drops only once both are full; no word lost or doubled.
// Reset: the deque is empty (head and count zero) and ready at once; the store
// is not cleared, since only slots holding live words are ever read.
`timescale 1ns / 1ps

module double_ended_queue (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // mode [2:0], value [34:3], zero pad above
  input  logic [deq_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // status [1:0], data [33:2], count [44:34], zero pad above
  output logic [deq_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  import deq_pkg::*;

  logic [PTR_W-1:0]   head_r, head_nxt;
  logic [CNT_W-1:0]   occ_r, occ_nxt;
  logic               s1_valid_r;
  stage_t             s1_r, s1_nxt;
  logic               out_valid_r;
  status_t            out_status_r;
  logic [DATA_W-1:0]  out_data_r;
  logic [CNT_W-1:0]   out_count_r;

  mode_t              mode;
  logic [VALUE_W-1:0] value;
  logic               accept;
  logic               s1_move;
  logic               full;
  logic               empty;
  logic [PTR_W-1:0]   head_dec;
  logic [PTR_W-1:0]   head_inc;
  logic [PTR_W-1:0]   back_slot;
  logic [PTR_W-1:0]   tail_slot;
  logic               ram_we;
  logic               ram_re;
  logic [PTR_W-1:0]   ram_waddr;
  logic [PTR_W-1:0]   ram_raddr;
  logic [DATA_W-1:0]  ram_rdata;

  assign mode  = mode_t'(in_tdata[MODE_W-1:0]);
  assign value = in_tdata[MODE_W +: VALUE_W];

  assign s1_move   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s1_move;
  assign accept    = in_tvalid && in_tready;

  assign full      = (occ_r == FULL_COUNT);
  assign empty     = (occ_r == '0);
  assign head_dec  = (head_r == '0) ? LAST_SLOT : head_r - 1'b1;
  assign head_inc  = slot_add(head_r, PTR_W'(1));
  // occ_r below DEPTH here, so its low bits are the offset
  assign tail_slot = slot_add(head_r, occ_r[PTR_W-1:0]);
  assign back_slot = slot_add(head_r, PTR_W'(occ_r - 1'b1));

  always_comb begin
    head_nxt      = head_r;
    occ_nxt       = occ_r;
    s1_nxt.status = ST_OK;
    s1_nxt.rd     = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = head_dec;
    ram_raddr     = head_r;
    unique case (mode)
      MODE_PUSH_FRONT: begin
        if (full) begin
          s1_nxt.status = ST_FULL;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = head_dec;
          head_nxt  = head_dec;
          occ_nxt   = occ_r + 1'b1;
        end
      end
      MODE_PUSH_BACK: begin
        if (full) begin
          s1_nxt.status = ST_FULL;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = tail_slot;
          occ_nxt   = occ_r + 1'b1;
        end
      end
      MODE_POP_FRONT: begin
        if (empty) begin
          s1_nxt.status = ST_EMPTY;
        end else begin
          s1_nxt.rd = 1'b1;
          ram_raddr = head_r;
          head_nxt  = head_inc;
          occ_nxt   = occ_r - 1'b1;
        end
      end
      MODE_POP_BACK: begin
        if (empty) begin
          s1_nxt.status = ST_EMPTY;
        end else begin
          s1_nxt.rd = 1'b1;
          ram_raddr = back_slot;
          occ_nxt   = occ_r - 1'b1;
        end
      end
      MODE_PEEK_FRONT: begin
        if (empty) begin
          s1_nxt.status = ST_EMPTY;
        end else begin
          s1_nxt.rd = 1'b1;
          ram_raddr = head_r;
        end
      end
      MODE_PEEK_BACK: begin
        if (empty) begin
          s1_nxt.status = ST_EMPTY;
        end else begin
          s1_nxt.rd = 1'b1;
          ram_raddr = back_slot;
        end
      end
      MODE_SIZE: begin
      end
      MODE_CLEAR: begin
        head_nxt = '0;
        occ_nxt  = '0;
      end
    endcase
    s1_nxt.count = occ_nxt;
  end

  assign ram_re = accept && s1_nxt.rd;

  deq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (accept && ram_we),
    .waddr (ram_waddr),
    .wdata (value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      occ_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        head_r <= head_nxt;
        occ_r  <= occ_nxt;
      end
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (s1_move) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= s1_nxt;
    end
    if (s1_move && s1_valid_r) begin
      out_status_r <= s1_r.status;
      out_data_r   <= s1_r.rd ? ram_rdata : '0;
      out_count_r  <= s1_r.count;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({out_count_r, out_data_r, out_status_r});

endmodule
